@@ rtl/smss_pkg.sv @@
// ----------------------------------------------------------------------------
// smss_pkg: shared types and constants of the staircase search block
// Default capacity, field widths, opcodes, register indexes, the walker state encoding and the result type.
// ----------------------------------------------------------------------------
package smss_pkg;

  // default matrix capacity
  localparam int unsigned MAX_ROWS_DEF = 16;
  localparam int unsigned MAX_COLS_DEF = 16;

  // fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned DIM_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // input opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  // walker sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } walk_state_e;

  // one search result
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] hit_row;
    logic [POS_W-1:0] hit_col;
  } result_t;

endpackage

@@ rtl/smss_store.sv @@
// ----------------------------------------------------------------------------
// smss_store: entry memory
// One write port and one registered read port, addressed by row and column.
// ----------------------------------------------------------------------------
module smss_store #(
  parameter int unsigned MAX_ROWS = smss_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smss_pkg::MAX_COLS_DEF,
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [RW-1:0]                      wr_row_i,
  input  logic [CW-1:0]                      wr_col_i,
  input  logic [smss_pkg::VALUE_W-1:0]       wr_data_i,
  input  logic [RW-1:0]                      rd_row_i,
  input  logic [CW-1:0]                      rd_col_i,
  output logic [smss_pkg::VALUE_W-1:0]       rd_data_o
);

  logic [smss_pkg::VALUE_W-1:0] mem_q [MAX_ROWS][MAX_COLS];

  // write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_row_i][wr_col_i] <= wr_data_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_row_i][rd_col_i];
  end

endmodule

@@ rtl/smss_walker.sv @@
// ----------------------------------------------------------------------------
// smss_walker: staircase search sequencer
// Steps a cursor from the top-right corner, one memory read and one signed
// compare per cycle, and strobes the result when the walk ends.
// ----------------------------------------------------------------------------
module smss_walker #(
  parameter int unsigned MAX_ROWS = smss_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smss_pkg::MAX_COLS_DEF,
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1),
  localparam int unsigned CCW = $clog2(MAX_COLS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               search_i,
  input  logic [smss_pkg::VALUE_W-1:0]       key_i,
  input  logic [smss_pkg::DIM_W-1:0]         rows_i,
  input  logic [smss_pkg::DIM_W-1:0]         cols_i,
  output logic [RW-1:0]                      rd_row_o,
  output logic [CW-1:0]                      rd_col_o,
  input  logic [smss_pkg::VALUE_W-1:0]       rd_data_i,
  output logic                               busy_o,
  output logic                               done_o,
  output smss_pkg::result_t                  result_o
);

  smss_pkg::walk_state_e state_q, state_d;
  logic [RCW-1:0]               row_q, row_d;
  logic [CW-1:0]                col_q, col_d;
  logic [RCW-1:0]               nr_q, nr_d;
  logic [smss_pkg::VALUE_W-1:0] key_q, key_d;
  logic                         done_q, done_d;
  smss_pkg::result_t            res_q, res_d;

  logic [RCW-1:0] nr_clamp;
  logic [CCW-1:0] nc_clamp;
  logic [RCW-1:0] row_inc;
  logic           eq;
  logic           gt;

  // saturate the region size to the store size
  assign nr_clamp = (rows_i > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_i);
  assign nc_clamp = (cols_i > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_i);

  // shared compare unit
  assign eq      = (rd_data_i == key_q);
  assign gt      = ($signed(rd_data_i) > $signed(key_q));
  assign row_inc = RCW'(row_q + 1'b1);

  // next state and cursor
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    nr_d    = nr_q;
    key_d   = key_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      smss_pkg::ST_IDLE: begin
        if (search_i) begin
          key_d = key_i;
          nr_d  = nr_clamp;
          row_d = '0;
          if (nr_clamp == '0 || nc_clamp == '0) begin
            col_d  = '0;
            done_d = 1'b1;
            res_d  = '0;
          end else begin
            col_d   = CW'(nc_clamp - 1'b1);
            state_d = smss_pkg::ST_WALK;
          end
        end
      end
      smss_pkg::ST_WALK: begin
        if (eq) begin
          done_d        = 1'b1;
          res_d.found   = 1'b1;
          res_d.hit_row = smss_pkg::POS_W'(row_q);
          res_d.hit_col = smss_pkg::POS_W'(col_q);
          state_d       = smss_pkg::ST_IDLE;
        end else if (gt) begin
          if (col_q == '0) begin
            done_d  = 1'b1;
            res_d   = '0;
            state_d = smss_pkg::ST_IDLE;
          end else begin
            col_d = col_q - 1'b1;
          end
        end else begin
          row_d = row_inc;
          if (row_inc >= nr_q) begin
            done_d  = 1'b1;
            res_d   = '0;
            state_d = smss_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = smss_pkg::ST_IDLE;
      end
    endcase
  end

  // read the entry under the next cursor position
  assign rd_row_o = RW'(row_d);
  assign rd_col_o = col_d;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smss_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nr_q  <= nr_d;
    key_q <= key_d;
    res_q <= res_d;
  end

  assign busy_o   = (state_q == smss_pkg::ST_WALK);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/sorted_matrix_staircase_search_top.sv @@
// Search: the accepting edge loads the cursor and reads the first entry; each
// walk step does one memory read and one compare, and the result strobe is
// registered; an empty region needs no walk. busy is high for the walk.
// Load: written at the accepting edge, one per cycle when idle, no result.
// done_o pulses one cycle; the receiver cannot stall; the last result is held.
// Reset (rst_ni low, asynchronous) idles the walker and sets both region
// sizes to 16; the entry memory keeps its contents, undefined until written.
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search_top: staircase search over a sorted matrix
// Holds the region registers and routes loads to the memory and searches to
// the walker.
// ----------------------------------------------------------------------------
module sorted_matrix_staircase_search_top #(
  parameter int unsigned MAX_ROWS = smss_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smss_pkg::MAX_COLS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op_i,
  input  logic [smss_pkg::POS_W-1:0]         row_i,
  input  logic [smss_pkg::POS_W-1:0]         col_i,
  input  logic [smss_pkg::VALUE_W-1:0]       value_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [smss_pkg::POS_W-1:0]         hit_row_o,
  output logic [smss_pkg::POS_W-1:0]         hit_col_o,
  input  logic                               cfg_we_i,
  input  logic [smss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [smss_pkg::DIM_W-1:0]         cfg_data_i
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [smss_pkg::DIM_W-1:0]   rows_q;
  logic [smss_pkg::DIM_W-1:0]   cols_q;
  logic                         accept;
  logic                         load_we;
  logic                         search;
  logic [RW-1:0]                rd_row;
  logic [CW-1:0]                rd_col;
  logic [smss_pkg::VALUE_W-1:0] rd_data;
  smss_pkg::result_t            result;

  // region size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= smss_pkg::DIM_W'(16);
      cols_q <= smss_pkg::DIM_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smss_pkg::REG_ROWS_IN_USE: rows_q <= cfg_data_i;
        smss_pkg::REG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode the accepted transaction; drop loads outside the store
  assign accept  = start && !busy;
  assign search  = accept && (op_i == smss_pkg::OP_SEARCH);
  assign load_we = accept && (op_i == smss_pkg::OP_LOAD) &&
                   (row_i < MAX_ROWS) && (col_i < MAX_COLS);

  smss_store #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (load_we),
    .wr_row_i  (RW'(row_i)),
    .wr_col_i  (CW'(col_i)),
    .wr_data_i (value_i),
    .rd_row_i  (rd_row),
    .rd_col_i  (rd_col),
    .rd_data_o (rd_data)
  );

  smss_walker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .search_i  (search),
    .key_i     (value_i),
    .rows_i    (rows_q),
    .cols_i    (cols_q),
    .rd_row_o  (rd_row),
    .rd_col_o  (rd_col),
    .rd_data_i (rd_data),
    .busy_o    (busy),
    .done_o    (done_o),
    .result_o  (result)
  );

  assign found_o   = result.found;
  assign hit_row_o = result.hit_row;
  assign hit_col_o = result.hit_col;

endmodule

@@ rtl/smss_checker.sv @@
// ----------------------------------------------------------------------------
// smss_checker: port-level checks of the staircase search block
// Relates accepted transactions to busy and the result strobe.
// ----------------------------------------------------------------------------
module smss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        op_i,
  input logic                        done_o,
  input logic                        found_o,
  input logic [smss_pkg::POS_W-1:0]  hit_row_o,
  input logic [smss_pkg::POS_W-1:0]  hit_col_o
);

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (hit_row_o == '0 && hit_col_o == '0))
    else $error("miss result with nonzero position");

  // a load leaves the block idle and yields no result
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == smss_pkg::OP_LOAD) |=> (!busy && !done_o))
    else $error("load transaction made the block busy or strobe a result");

  // a search either walks or answers at once
  a_search_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == smss_pkg::OP_SEARCH) |=> (busy || done_o))
    else $error("search transaction was lost");

  // a result follows a walk or a search transaction
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(rst_ni)) |->
      ($past(busy) || ($past(start) && $past(op_i) == smss_pkg::OP_SEARCH))
    ) else $error("result strobe without a search");

  // the strobe ends the walk
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still walking");

endmodule

bind sorted_matrix_staircase_search_top smss_checker u_smss_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .op_i      (op_i),
  .done_o    (done_o),
  .found_o   (found_o),
  .hit_row_o (hit_row_o),
  .hit_col_o (hit_col_o)
);
